FILE: src/sdt_pkg.sv
// ----------------------------------------------------------------------------
// Sub-interrupt dispatch table package
// Shared types, codes and default sizes for the dispatch table block.
// ----------------------------------------------------------------------------
package sdt_pkg;

  localparam int NUM_INTR_DEF      = 67;
  localparam int SUBS_PER_INTR_DEF = 32;
  localparam int QUEUE_DEPTH_DEF   = 64;
  localparam int GE_INTR_NUM_DEF   = 25;

  localparam logic [2:0] ACT_REGISTER = 3'd0;
  localparam logic [2:0] ACT_RELEASE  = 3'd1;
  localparam logic [2:0] ACT_ENABLE   = 3'd2;
  localparam logic [2:0] ACT_DISABLE  = 3'd3;
  localparam logic [2:0] ACT_TRIGGER  = 3'd4;
  localparam logic [2:0] ACT_RETURN   = 3'd5;

  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_ILLEGAL    = 3'd1;
  localparam logic [2:0] STS_REGISTERED = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND  = 3'd3;
  localparam logic [2:0] STS_OVERFLOW   = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [6:0]  intr_num;
    logic [5:0]  sub_num;
    logic        all_subs;
    logic [31:0] handler_address;
    logic [31:0] handler_arg;
    logic signed [31:0] ge_arg;
    logic        interrupts_on;
  } sdt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        dispatched;
    logic [31:0] dispatch_address;
    logic [31:0] arg_a0;
    logic [31:0] arg_a1;
    logic        clear_a2;
    logic        reschedule;
    logic [5:0]  queued_count;
  } sdt_out_t;

  // One pending queue entry.
  typedef struct packed {
    logic [6:0]  intr;
    logic [4:0]  sub;
    logic [31:0] ge;
  } sdt_pend_t;

  // One handler table word.
  typedef struct packed {
    logic        en;
    logic [31:0] arg;
    logic [31:0] addr;
  } sdt_hdl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sdt_qstat_t;

endpackage

FILE: src/subinterrupt_dispatch_table_top.sv
// ----------------------------------------------------------------------------
// Sub-interrupt dispatch table
// Handler table in one memory, pending queue, trigger scan and dispatch.
// ----------------------------------------------------------------------------
// An illegal item or a trigger with interrupts off strobes its result in the cycle
// after it is taken. Register, release, enable and disable pass through the modify
// state; a return goes to the dequeue state; a trigger first scans its subs (up to
// SUBS_PER_INTR), then dequeues. A dispatch adds the table read and output states.
// One item at a time; busy is low at each strobe. After reset the table is swept
// to zero, one entry per cycle, with busy high. The receiver cannot stall.
module subinterrupt_dispatch_table_top #(
  parameter int NUM_INTR      = sdt_pkg::NUM_INTR_DEF,
  parameter int SUBS_PER_INTR = sdt_pkg::SUBS_PER_INTR_DEF,
  parameter int QUEUE_DEPTH   = sdt_pkg::QUEUE_DEPTH_DEF,
  parameter int GE_INTR_NUM   = sdt_pkg::GE_INTR_NUM_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  sdt_pkg::sdt_in_t in_item,
  output logic             out_strobe,
  output sdt_pkg::sdt_out_t out_item
);
  import sdt_pkg::*;

  localparam int TBL_SIZE = NUM_INTR * SUBS_PER_INTR;
  localparam int TBL_AW   = $clog2(TBL_SIZE);

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MOD    = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DQ     = 3'd4;
  localparam logic [2:0] ST_DQ_TB  = 3'd5;
  localparam logic [2:0] ST_DQ_OUT = 3'd6;

  function automatic logic [TBL_AW-1:0] slot_of(input logic [6:0] i, input logic [4:0] s);
    logic [31:0] t;
    t = 32'(i) * 32'(SUBS_PER_INTR) + 32'(s);
    return t[TBL_AW-1:0];
  endfunction

  logic [2:0]        state_r;
  logic [TBL_AW-1:0] clr_r;
  logic              in_intr_r;
  logic [2:0]        act_r;
  logic [TBL_AW-1:0] slot_r;
  logic [6:0]        intr_r;
  logic [31:0]       ge_r;
  logic [31:0]       haddr_r;
  logic [4:0]        chk_r;
  logic [4:0]        last_r;
  logic [2:0]        status_r;
  logic [5:0]        queued_r;
  logic              ret_r;
  logic              out_strobe_r;
  sdt_out_t          out_item_r;

  sdt_hdl_t          tbl_mem [TBL_SIZE];
  sdt_hdl_t          tbl_rdata_r;
  logic [TBL_AW-1:0] tbl_raddr;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  sdt_hdl_t          tbl_wdata;

  logic              q_push;
  logic              q_pop;
  sdt_pend_t         q_push_data;
  sdt_pend_t         q_head;
  sdt_qstat_t        q_stat;

  logic              accept;
  logic              intr_ok;
  logic              sub_ok;
  logic              scan_hit;
  logic              is_ge;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign intr_ok = (32'(in_item.intr_num) < NUM_INTR);
  assign sub_ok  = (32'(in_item.sub_num) < SUBS_PER_INTR);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Table read address follows the state that consumes the data next cycle.
  always_comb begin
    unique case (state_r)
      ST_IDLE:  tbl_raddr = slot_of(in_item.intr_num,
                                    in_item.all_subs && (in_item.action == ACT_TRIGGER)
                                    ? 5'd0 : in_item.sub_num[4:0]);
      ST_SCAN:  tbl_raddr = slot_of(intr_r, chk_r + 5'd1);
      ST_DQ_TB: tbl_raddr = slot_of(q_head.intr, q_head.sub);
      default:  tbl_raddr = slot_r;
    endcase
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = slot_r;
    tbl_wdata = tbl_rdata_r;
    if (state_r == ST_CLR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_r;
      tbl_wdata = '0;
    end else if (state_r == ST_MOD) begin
      unique case (act_r)
        ACT_REGISTER: begin
          tbl_we    = (tbl_rdata_r.addr == '0);
          tbl_wdata = '{en: 1'b0, arg: ge_r, addr: haddr_r};
        end
        ACT_RELEASE: begin
          tbl_we    = (tbl_rdata_r.addr != '0);
          tbl_wdata = '0;
        end
        ACT_ENABLE: begin
          tbl_we       = 1'b1;
          tbl_wdata.en = 1'b1;
        end
        default: begin
          tbl_we       = 1'b1;
          tbl_wdata.en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata_r <= tbl_mem[tbl_raddr];
  end

  assign scan_hit    = (state_r == ST_SCAN) && tbl_rdata_r.en && (tbl_rdata_r.addr != '0);
  assign q_push      = scan_hit && !q_stat.full;
  assign q_push_data = '{intr: intr_r, sub: chk_r, ge: ge_r};
  assign q_pop       = (state_r == ST_DQ) && !in_intr_r && !q_stat.empty;
  assign is_ge       = (32'(q_head.intr) == GE_INTR_NUM);

  sdt_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_head),
    .stat     (q_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_r        <= '0;
      in_intr_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == TBL_AW'(TBL_SIZE - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            act_r    <= in_item.action;
            slot_r   <= tbl_raddr;
            intr_r   <= in_item.intr_num;
            status_r <= STS_OK;
            queued_r <= '0;
            ret_r    <= (in_item.action == ACT_RETURN);
            out_item_r <= '0;
            haddr_r  <= in_item.handler_address;
            // The register action carries its handler argument in the same register.
            ge_r     <= (in_item.action == ACT_REGISTER) ? in_item.handler_arg
                                                         : in_item.ge_arg;
            chk_r    <= in_item.all_subs ? 5'd0 : in_item.sub_num[4:0];
            last_r   <= in_item.all_subs ? 5'(SUBS_PER_INTR - 1) : in_item.sub_num[4:0];
            if (in_item.action == ACT_RETURN) begin
              in_intr_r <= 1'b0;
              state_r   <= ST_DQ;
            end else if (in_item.action > ACT_RETURN || !intr_ok ||
                         (!sub_ok && !(in_item.action == ACT_TRIGGER && in_item.all_subs))) begin
              out_item_r.status <= STS_ILLEGAL;
              out_strobe_r      <= 1'b1;
            end else if (in_item.action == ACT_TRIGGER) begin
              if (in_item.interrupts_on) begin
                state_r <= ST_SCAN;
              end else begin
                out_strobe_r <= 1'b1;
              end
            end else begin
              state_r <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          out_item_r <= '0;
          if (act_r == ACT_REGISTER && tbl_rdata_r.addr != '0) begin
            out_item_r.status <= STS_REGISTERED;
          end else if (act_r == ACT_RELEASE && tbl_rdata_r.addr == '0) begin
            out_item_r.status <= STS_NOT_FOUND;
          end
          out_strobe_r <= 1'b1;
          state_r      <= ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_hit) begin
            if (q_stat.full) begin
              status_r <= STS_OVERFLOW;
            end else begin
              queued_r <= queued_r + 6'd1;
            end
          end
          chk_r <= chk_r + 5'd1;
          if (chk_r == last_r) begin
            state_r <= ST_DQ;
          end
        end
        ST_DQ: begin
          if (q_pop) begin
            state_r <= ST_DQ_TB;
          end else begin
            out_item_r              <= '0;
            out_item_r.status       <= status_r;
            out_item_r.queued_count <= queued_r;
            out_item_r.reschedule   <= ret_r;
            out_strobe_r            <= 1'b1;
            state_r                 <= ST_IDLE;
          end
        end
        ST_DQ_TB: begin
          state_r <= ST_DQ_OUT;
        end
        ST_DQ_OUT: begin
          out_item_r.status           <= status_r;
          out_item_r.dispatched       <= 1'b1;
          out_item_r.dispatch_address <= tbl_rdata_r.addr;
          out_item_r.arg_a0           <= is_ge ? q_head.ge : 32'(q_head.sub);
          out_item_r.arg_a1           <= tbl_rdata_r.arg;
          out_item_r.clear_a2         <= is_ge;
          out_item_r.reschedule       <= 1'b0;
          out_item_r.queued_count     <= queued_r;
          out_strobe_r                <= 1'b1;
          in_intr_r                   <= 1'b1;
          state_r                     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A result is only strobed once the block is ready for the next item.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobed while busy");

  // A dispatch always leaves the block inside an interrupt.
  a_disp_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.dispatched) |-> in_intr_r)
    else $error("dispatch without in-interrupt flag");

  // The queue is never pushed when full nor popped when empty.
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full) && !(q_pop && q_stat.empty))
    else $error("pending queue bound violated");

  // Nothing but the sweep is started while the table is being cleared.
  a_clr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |=> (state_r == ST_CLR || state_r == ST_IDLE) && !out_strobe)
    else $error("activity during table clear");
`endif

endmodule

FILE: src/sdt_fifo.sv
// ----------------------------------------------------------------------------
// Pending queue
// Memory based FIFO of pending interrupt items with registered read data.
// ----------------------------------------------------------------------------
module sdt_fifo #(
  parameter int DEPTH = sdt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sdt_pkg::sdt_pend_t push_data,
  input  logic               pop,
  output sdt_pkg::sdt_pend_t pop_data,
  output sdt_pkg::sdt_qstat_t stat
);
  import sdt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sdt_pend_t         mem [DEPTH];
  logic [PW-1:0]     head_r;
  logic [PW-1:0]     tail_r;
  logic [CW-1:0]     count_r;
  sdt_pend_t         pop_data_r;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = pop_data_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= push_data;
    end
    if (pop) begin
      pop_data_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        tail_r <= (tail_r == PW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
      end
      if (pop) begin
        head_r <= (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Dispatch table testbench
// Drives register, release, enable, disable, trigger and return items into
// the dispatch table, predicts every result from a local copy of the table,
// pending queue and in-interrupt flag, and compares each strobed result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sdt_pkg::*;

  localparam int NINTR = NUM_INTR_DEF;
  localparam int NSUB  = SUBS_PER_INTR_DEF;
  localparam int QDEP  = QUEUE_DEPTH_DEF;
  localparam int GEI   = GE_INTR_NUM_DEF;
  localparam int WATCH_LIMIT = 40000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  sdt_in_t in_item;
  logic out_strobe;
  sdt_out_t out_item;

  subinterrupt_dispatch_table_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  // Predictor state.
  logic [31:0] h_addr [NINTR*NSUB];
  logic [31:0] h_arg [NINTR*NSUB];
  logic h_en [NINTR*NSUB];
  sdt_pend_t pend_q[$];
  logic in_irq;

  sdt_in_t pending_items[$];
  sdt_out_t expected_results[$];
  int errors = 0;
  int n_results = 0;
  int n_dispatch = 0;
  int n_overflow = 0;
  int sender_idle = 36;
  logic hold_off = 0;
  int idle_cycles = 0;

  function automatic void start_head(inout sdt_out_t r);
    sdt_pend_t e;
    int s;
    if (in_irq || pend_q.size() == 0) return;
    e = pend_q.pop_front();
    s = e.intr * NSUB + e.sub;
    r.dispatched = 1;
    r.dispatch_address = h_addr[s];
    r.arg_a0 = (e.intr == GEI) ? e.ge : 32'(e.sub);
    r.arg_a1 = h_arg[s];
    r.clear_a2 = (e.intr == GEI);
    in_irq = 1;
  endfunction

  function automatic sdt_out_t predict_dispatch(sdt_in_t it);
    sdt_out_t r;
    int s;
    int cnt;
    sdt_pend_t e;
    r = '0;
    if (it.action == ACT_RETURN) begin
      in_irq = 0;
      start_head(r);
      if (!r.dispatched) r.reschedule = 1;
      return r;
    end
    if (it.action > ACT_RETURN || it.intr_num >= NINTR ||
        (it.sub_num >= NSUB && !(it.action == ACT_TRIGGER && it.all_subs))) begin
      r.status = STS_ILLEGAL;
      return r;
    end
    s = it.intr_num * NSUB + ((it.sub_num < NSUB) ? it.sub_num : 0);
    r.status = STS_OK;
    case (it.action)
      ACT_REGISTER: begin
        if (h_addr[s] != 0) r.status = STS_REGISTERED;
        else begin
          h_addr[s] = it.handler_address;
          h_arg[s] = it.handler_arg;
          h_en[s] = 0;
        end
      end
      ACT_RELEASE: begin
        if (h_addr[s] == 0) r.status = STS_NOT_FOUND;
        else begin
          h_addr[s] = 0;
          h_arg[s] = 0;
          h_en[s] = 0;
        end
      end
      ACT_ENABLE: h_en[s] = 1;
      ACT_DISABLE: h_en[s] = 0;
      default: begin
        if (it.interrupts_on) begin
          cnt = 0;
          for (int k = 0; k < NSUB; k++) begin
            if (!it.all_subs && k != it.sub_num) continue;
            s = it.intr_num * NSUB + k;
            if (h_en[s] && h_addr[s] != 0) begin
              if (pend_q.size() >= QDEP) r.status = STS_OVERFLOW;
              else begin
                e.intr = it.intr_num;
                e.sub = 5'(k);
                e.ge = it.ge_arg;
                pend_q.push_back(e);
                cnt++;
              end
            end
          end
          r.queued_count = 6'(cnt);
          start_head(r);
        end
      end
    endcase
    return r;
  endfunction

  function automatic sdt_in_t make_item(logic [2:0] act, int intr, int sub,
                                        logic all, logic ion);
    sdt_in_t it;
    it.action = act;
    it.intr_num = 7'(intr);
    it.sub_num = 6'(sub);
    it.all_subs = all;
    it.handler_address = $urandom();
    it.handler_arg = $urandom();
    it.ge_arg = $urandom();
    it.interrupts_on = ion;
    return it;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_item <= '0;
    end else if (start && !busy) begin
      expected_results.push_back(predict_dispatch(in_item));
      if (pending_items.size() > 0 && !hold_off &&
          $urandom_range(99) >= sender_idle) begin
        in_item <= pending_items.pop_front();
      end else begin
        start <= 0;
      end
    end else if (!start && pending_items.size() > 0 && !hold_off &&
                 $urandom_range(99) >= sender_idle) begin
      start <= 1;
      in_item <= pending_items.pop_front();
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sdt_out_t e;
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = expected_results.pop_front();
        n_results++;
        if (e.dispatched) n_dispatch++;
        if (e.status == STS_OVERFLOW) n_overflow++;
        if (out_item.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_item.status); errors++;
        end
        if (out_item.dispatched !== e.dispatched) begin
          $error("dispatched exp %0d got %0d", e.dispatched, out_item.dispatched);
          errors++;
        end
        if (out_item.dispatch_address !== e.dispatch_address) begin
          $error("dispatch_address exp %h got %h", e.dispatch_address,
                 out_item.dispatch_address); errors++;
        end
        if (out_item.arg_a0 !== e.arg_a0) begin
          $error("arg_a0 exp %h got %h", e.arg_a0, out_item.arg_a0); errors++;
        end
        if (out_item.arg_a1 !== e.arg_a1) begin
          $error("arg_a1 exp %h got %h", e.arg_a1, out_item.arg_a1); errors++;
        end
        if (out_item.clear_a2 !== e.clear_a2) begin
          $error("clear_a2 exp %0d got %0d", e.clear_a2, out_item.clear_a2); errors++;
        end
        if (out_item.reschedule !== e.reschedule) begin
          $error("reschedule exp %0d got %0d", e.reschedule, out_item.reschedule);
          errors++;
        end
        if (out_item.queued_count !== e.queued_count) begin
          $error("queued_count exp %0d got %0d", e.queued_count,
                 out_item.queued_count); errors++;
        end
      end
    end
  end

  // Watchdog: cycles with neither an accepted item nor a result.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_item(sdt_in_t it);
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
  endtask

  // Random sequence: mostly well-formed register/enable/trigger/return chains.
  task automatic add_random_burst();
    int intr;
    int sub;
    int pick;
    intr = ($urandom_range(9) == 0) ? $urandom_range(127) :
           ($urandom_range(2) == 0 ? GEI : $urandom_range(7));
    sub = ($urandom_range(11) == 0) ? $urandom_range(63) : $urandom_range(7);
    pick = $urandom_range(99);
    if (pick < 20) begin
      add_item(make_item(ACT_REGISTER, intr, sub, 0, 1));
      add_item(make_item(ACT_ENABLE, intr, sub, 0, 1));
    end else if (pick < 45) begin
      add_item(make_item(ACT_TRIGGER, intr, sub, $urandom_range(2) == 0,
                         $urandom_range(7) != 0));
    end else if (pick < 70) begin
      add_item(make_item(ACT_RETURN, $urandom_range(127), $urandom_range(63),
                         1'($urandom_range(1)), 1'($urandom_range(1))));
    end else if (pick < 78) begin
      add_item(make_item(ACT_RELEASE, intr, sub, 1'($urandom_range(1)), 1));
    end else if (pick < 86) begin
      add_item(make_item(ACT_DISABLE, intr, sub, 1'($urandom_range(1)), 1));
    end else if (pick < 93) begin
      add_item(make_item(ACT_ENABLE, intr, sub, 1'($urandom_range(1)), 1));
    end else begin
      add_item(make_item(3'($urandom_range(7)), $urandom_range(127),
                         $urandom_range(63), 1'($urandom_range(1)),
                         1'($urandom_range(1))));
    end
  endtask

  initial begin
    sdt_in_t it;
    for (int i = 0; i < NINTR*NSUB; i++) begin
      h_addr[i] = 0; h_arg[i] = 0; h_en[i] = 0;
    end
    in_irq = 0;
    rst_n = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // Directed part: field extremes, each action and the special cases.
    it = make_item(ACT_REGISTER, 66, 31, 0, 1);
    it.handler_address = '1; it.handler_arg = '1;
    add_item(it);
    add_item(make_item(ACT_REGISTER, 66, 31, 0, 1));   // already registered
    add_item(make_item(ACT_REGISTER, 67, 0, 0, 1));    // bad interrupt
    add_item(make_item(ACT_REGISTER, 127, 63, 1, 1));
    add_item(make_item(ACT_ENABLE, 0, 32, 0, 1));      // bad sub
    add_item(make_item(ACT_ENABLE, 66, 31, 0, 1));
    add_item(make_item(ACT_ENABLE, 0, 0, 0, 1));       // enable with no handler
    add_item(make_item(ACT_TRIGGER, 0, 0, 0, 1));      // nothing queued
    add_item(make_item(ACT_TRIGGER, 66, 31, 0, 0));    // interrupts off
    add_item(make_item(ACT_TRIGGER, 66, 63, 1, 1));    // all subs ignores sub
    add_item(make_item(ACT_TRIGGER, 66, 31, 0, 1));    // queued while in interrupt
    it = make_item(ACT_REGISTER, GEI, 5, 0, 1);
    add_item(it);
    add_item(make_item(ACT_ENABLE, GEI, 5, 0, 1));
    it = make_item(ACT_TRIGGER, GEI, 5, 0, 1);
    it.ge_arg = 32'sh8000_0000;
    add_item(it);
    add_item(make_item(ACT_RELEASE, 66, 31, 0, 1));    // queued entry released
    add_item(make_item(ACT_RELEASE, 66, 31, 0, 1));    // not found
    add_item(make_item(ACT_RETURN, 0, 0, 0, 0));
    add_item(make_item(ACT_RETURN, 127, 63, 1, 1));
    add_item(make_item(ACT_RETURN, 0, 0, 0, 0));
    add_item(make_item(ACT_RETURN, 0, 0, 0, 0));       // reschedule
    add_item(make_item(3'd6, 0, 0, 0, 1));
    add_item(make_item(3'd7, 127, 63, 1, 1));
    add_item(make_item(ACT_DISABLE, GEI, 5, 0, 1));

    // Fill interrupt 3 fully so all-sub triggers overflow the queue.
    for (int k = 0; k < NSUB; k++) begin
      add_item(make_item(ACT_REGISTER, 3, k, 0, 1));
      add_item(make_item(ACT_ENABLE, 3, k, 0, 1));
    end
    for (int j = 0; j < 3; j++) add_item(make_item(ACT_TRIGGER, 3, 0, 1, 1));
    wait_drained();

    // Random parts under three idle profiles.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle = (phase == 0) ? 36 : (phase == 1) ? 53 : 0;
      for (int n = 0; n < 390; n++) add_random_burst();
      if (phase == 1) begin
        // Stop sending midway and let every outstanding result come back.
        while (pending_items.size() > 200) @(posedge clk);
        hold_off = 1;
        while (start || expected_results.size() > 0) @(posedge clk);
        hold_off = 0;
      end
      wait_drained();
    end
    // Drain any pending interrupts with returns.
    for (int n = 0; n < QDEP + 2; n++) add_item(make_item(ACT_RETURN, 0, 0, 0, 0));
    wait_drained();
    repeat (50) @(posedge clk);

    $display("Checked %0d results: %0d dispatches, %0d queue overflows.",
             n_results, n_dispatch, n_overflow);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
